>>> rtl/fmbq_pkg.sv
// fmbq_pkg: command and status codes and the per-cell control beat
// shared by the front/middle/back queue cells and the top level
// no dependencies
package fmbq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT  = 3'd0,
    CMD_PUSH_MIDDLE = 3'd1,
    CMD_PUSH_BACK   = 3'd2,
    CMD_POP_FRONT   = 3'd3,
    CMD_POP_MIDDLE  = 3'd4,
    CMD_POP_BACK    = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell along with the position
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

>>> rtl/front_middle_back_queue_core.sv
// front_middle_back_queue_core: bounded queue with push/pop at front,
// middle and back, built as a row of shifting cells with an output register
// depends on fmbq_pkg and fmbq_cell
//
//   channel | handshake          | payload
//   in      | in_valid, in_stall | command, value
//   out     | out_valid, out_stall | popped_value, status
//
// one command per cycle while in_stall is low; every cell shifts, loads or holds in parallel
// a result appears the cycle after its command beat
// a new beat is taken while the previous result is being taken
// in_stall is high only while a result waits under out_stall
// rst clears the count and out_valid; cell data is unset
module front_middle_back_queue_core import fmbq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] popped_value,
  output logic [1:0]  status
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                  in_accept;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      pos_wide;
  logic [IDX_W-1:0]      pos;
  cell_ctl_t             ctl;
  status_t               st_next;
  logic                  is_pop_ok;
  logic [DATA_WIDTH+31:0] val_ext;
  logic [DATA_WIDTH-1:0] load_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [DATA_WIDTH-1:0] sel_data;
  logic [DATA_WIDTH+31:0] pop_ext;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign val_ext   = {{DATA_WIDTH{1'b0}}, value};
  assign load_data = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    ctl        = '0;
    pos_wide   = '0;
    st_next    = ST_DONE;
    is_pop_ok  = 1'b0;
    count_next = count;
    unique case (command)
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (count >= CAP_CNT) begin
          st_next = ST_FULL;
        end else begin
          ctl.ins    = in_accept;
          count_next = count + CNT_W'(1);
          if (command == CMD_PUSH_MIDDLE) begin
            pos_wide = count >> 1;
          end else if (command == CMD_PUSH_BACK) begin
            pos_wide = count;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          ctl.rem    = in_accept;
          is_pop_ok  = 1'b1;
          count_next = count - CNT_W'(1);
          if (command == CMD_POP_MIDDLE) begin
            pos_wide = (count - CNT_W'(1)) >> 1;
          end else if (command == CMD_POP_BACK) begin
            pos_wide = count - CNT_W'(1);
          end
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  assign pos = pos_wide[IDX_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = load_data;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end
    fmbq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos),
      .load_data (load_data),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .tap       (cell_tap[i])
    );
  end

  always_comb begin
    sel_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_data = sel_data | cell_tap[k];
    end
  end

  assign pop_ext = {32'd0, (is_pop_ok ? sel_data : {DATA_WIDTH{1'b0}})};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      popped_value <= pop_ext[31:0];
      status       <= st_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("queue count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == CAP_CNT))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (count == '0))
    else $error("empty status with entries held");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_accept))
    else $error("result without a command beat");
`endif

endmodule

>>> rtl/fmbq_cell.sv
// fmbq_cell: one queue slot; shifts toward the back on insert, toward the
// front on remove, loads the new value at the insert point
// depends on fmbq_pkg
module fmbq_cell import fmbq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (MY_IDX > pos) begin
        data_next = prev_data;
      end else if (MY_IDX == pos) begin
        data_next = load_data;
      end
    end else if (ctl.rem) begin
      if (MY_IDX >= pos) begin
        data_next = next_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign tap = (MY_IDX == pos) ? data : '0;

endmodule

>>> tb/front_middle_back_queue_core_tb.sv
`timescale 1ns / 1ps
// front_middle_back_queue_core_tb: directed and random push/pop commands, each
// result beat checked against a queue model kept here; depends on fmbq_pkg
// and front_middle_back_queue_core
module front_middle_back_queue_core_tb;
  import fmbq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int IDLE_LIMIT = 500;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [31:0] popped;
    status_t     st;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] popped_value;
  logic [1:0]  status;

  logic [31:0] model_entries[$];
  outcome_t    queued_outcomes[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  always #5 clk = ~clk;

  front_middle_back_queue_core #(
    .CAPACITY(CAPACITY),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .popped_value(popped_value),
    .status(status)
  );

  function automatic void compute_outcome(input logic [2:0] cmd, input logic [31:0] val);
    outcome_t res;
    int n;
    n = model_entries.size();
    res.popped = '0;
    res.st = ST_DONE;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
        if (n >= CAPACITY) res.st = ST_FULL;
        else if (cmd == CMD_PUSH_FRONT) model_entries.insert(0, val);
        else if (cmd == CMD_PUSH_MIDDLE) model_entries.insert(n / 2, val);
        else model_entries.insert(n, val);
      end
      CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
        if (n == 0) res.st = ST_EMPTY;
        else if (cmd == CMD_POP_FRONT) begin
          res.popped = model_entries[0];
          model_entries.delete(0);
        end else if (cmd == CMD_POP_BACK) begin
          res.popped = model_entries[n - 1];
          model_entries.delete(n - 1);
        end else begin
          res.popped = model_entries[(n - 1) / 2];
          model_entries.delete((n - 1) / 2);
        end
      end
      default: ;
    endcase
    queued_outcomes.insert(queued_outcomes.size(), res);
  endfunction

  task automatic send_beat(input logic [2:0] cmd, input logic [31:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (in_stall);
    compute_outcome(cmd, val);
  endtask

  task automatic test_empty_queue();
    send_beat(CMD_POP_FRONT, '1);
    send_beat(CMD_POP_MIDDLE, '1);
    send_beat(CMD_POP_BACK, '0);
    send_beat(CMD_SPARE_LO, '1);
    send_beat(CMD_SPARE_HI, 32'h1234_5678);
  endtask

  task automatic test_fill_to_capacity();
    logic [2:0] cmd;
    logic [31:0] val;
    for (int i = 0; i < CAPACITY + 3; i++) begin
      case (i % 3)
        0: cmd = CMD_PUSH_FRONT;
        1: cmd = CMD_PUSH_MIDDLE;
        default: cmd = CMD_PUSH_BACK;
      endcase
      if (i == 0) val = '0;
      else if (i == 1) val = '1;
      else val = $urandom;
      send_beat(cmd, val);
    end
    send_beat(CMD_POP_MIDDLE, '0);
    send_beat(CMD_POP_FRONT, '0);
    send_beat(CMD_POP_BACK, '1);
  endtask

  task automatic test_random_mix(input int beats);
    int sent;
    int push_pct;
    int block;
    logic [2:0] cmd;
    logic [31:0] val;
    sent = 0;
    while (sent < beats) begin
      // vary the push/pop balance so the fill level sweeps empty to full
      case ($urandom_range(0, 3))
        0: push_pct = 15;
        1: push_pct = 50;
        2: push_pct = 85;
        default: push_pct = 97;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      block = $urandom_range(10, 60);
      repeat (block) begin
        if ($urandom_range(0, 99) < 3) begin
          cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        end else if ($urandom_range(0, 99) < push_pct) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_PUSH_FRONT;
            1: cmd = CMD_PUSH_MIDDLE;
            default: cmd = CMD_PUSH_BACK;
          endcase
          sent++;
        end else begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_POP_FRONT;
            1: cmd = CMD_POP_MIDDLE;
            default: cmd = CMD_POP_BACK;
          endcase
          sent++;
        end
        case ($urandom_range(0, 9))
          0: val = '0;
          1: val = '1;
          default: val = $urandom;
        endcase
        send_beat(cmd, val);
      end
    end
    no_idle = 1'b0;
  endtask

  // result side: random stall before each beat
  initial begin
    int hold;
    do @(posedge clk); while (rst);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    outcome_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (queued_outcomes.size() == 0) begin
        $error("unexpected beat: popped_value %h status %0d", popped_value, status);
        mismatches++;
      end else begin
        exp_res = queued_outcomes[0];
        queued_outcomes.delete(0);
        if (popped_value !== exp_res.popped) begin
          $error("popped_value: expected %h, got %h", exp_res.popped, popped_value);
          mismatches++;
        end
        if (status !== exp_res.st) begin
          $error("status: expected %0d, got %0d", exp_res.st, status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_to_capacity();
    test_random_mix(800);
    in_valid <= 1'b0;
    while (queued_outcomes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
